// ===== sv/uvst_pkg.sv =====
// Shared types and codes for the unique value set table.
`default_nettype none
package uvst_pkg;

  // Default number of table entries.
  localparam int CAPACITY_DEF = 64;

  // Widths fixed by the request and result fields.
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic               cmp;     // compare phase: latch hit and select
    logic               do_del;  // delete phase: shift cells at and above the hit
    logic               do_add;  // add phase: write value into the tail cell
    logic [VALUE_W-1:0] value;   // value under test
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/uvst_cell.sv =====
// One table cell: holds an entry, compares it, and shifts toward lower positions on delete.
`default_nettype none
module uvst_cell #(
  parameter int XW  = 7,
  parameter int POS = 0
) (
  input  wire logic                        clk,
  input  wire uvst_pkg::cell_ctrl_t        ctrl,
  input  wire logic [XW-1:0]               count,
  input  wire logic [uvst_pkg::INDEX_W-1:0] index,
  input  wire logic [uvst_pkg::VALUE_W-1:0] entry_up,
  input  wire logic                        del_in,
  output logic [uvst_pkg::VALUE_W-1:0]     entry,
  output logic                             del_out,
  output logic                             hit,
  output logic [uvst_pkg::VALUE_W-1:0]     rd
);

  localparam logic [XW-1:0] MY_POS = XW'(POS);

  logic occupied;
  logic is_tail;
  logic sel;

  // Position checks against the current fill.
  assign occupied = MY_POS < count;
  assign is_tail  = MY_POS == count;

  // The deleted entry lies at or below this cell when either flag is set.
  assign del_out = del_in | hit;

  // Read data offered to the table-wide OR.
  assign rd = sel ? entry : '0;

  // Compare phase: record a match and whether this cell is the read target.
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      hit <= occupied && (entry == ctrl.value);
      sel <= MY_POS == XW'(index);
    end
  end

  // Update phase: shift down on delete, take the new value on add.
  always_ff @(posedge clk) begin
    if (ctrl.do_del && del_out) begin
      entry <= entry_up;
    end else if (ctrl.do_add && is_tail) begin
      entry <= ctrl.value;
    end
  end

endmodule
`default_nettype wire

// ===== sv/unique_value_set_table_unit.sv =====
// Top level of the unique value set table: sequencer, cell row and result register.
// A request is captured when accepted, then the cells compare it and the update phase
// writes the result register (accept, compare, update); done is high for one cycle.
// The next request enters only after the compare and update phases that each cell
// runs on the shared value; busy is high meanwhile.
// Reset clears the sequencer, the fill count and the strobe; entries keep no reset.
// The receiver cannot stall; each result is valid only while done is high.
`default_nettype none
module unique_value_set_table_unit #(
  parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         op,
  input  wire logic signed [uvst_pkg::VALUE_W-1:0] value,
  input  wire logic [uvst_pkg::INDEX_W-1:0]        index,
  output logic                                    done,
  output logic                                    found,
  output logic [uvst_pkg::COUNT_W-1:0]             count,
  output logic [1:0]                              status,
  output logic signed [uvst_pkg::VALUE_W-1:0]      element
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > uvst_pkg::COUNT_W) ? CW : uvst_pkg::COUNT_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  uvst_pkg::state_t state, state_next;

  // Captured request.
  uvst_pkg::op_t                 op_q;
  logic [uvst_pkg::VALUE_W-1:0]  value_q;
  logic [uvst_pkg::INDEX_W-1:0]  index_q;

  logic [XW-1:0] used;
  logic [XW-1:0] used_next;

  uvst_pkg::cell_ctrl_t ctrl;

  logic [uvst_pkg::VALUE_W-1:0] ent [CAPACITY];
  logic [uvst_pkg::VALUE_W-1:0] rdv [CAPACITY];
  logic [CAPACITY:0]            del_c;
  logic [CAPACITY-1:0]          hit_v;

  logic                         any_hit;
  logic [uvst_pkg::VALUE_W-1:0] rd_or;
  logic                         in_range;
  logic                         accept;
  uvst_pkg::status_t            status_next;
  logic [uvst_pkg::VALUE_W-1:0] element_next;

  assign accept = start && !busy;
  assign busy   = state != uvst_pkg::S_IDLE;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell controls.
  always_comb begin
    state_next   = state;
    ctrl.cmp     = 1'b0;
    ctrl.do_del  = 1'b0;
    ctrl.do_add  = 1'b0;
    ctrl.value   = value_q;
    case (state)
      uvst_pkg::S_IDLE: begin
        if (start) begin
          state_next = uvst_pkg::S_CMP;
        end
      end
      uvst_pkg::S_CMP: begin
        ctrl.cmp   = 1'b1;
        state_next = uvst_pkg::S_EXEC;
      end
      uvst_pkg::S_EXEC: begin
        ctrl.do_del = (op_q == uvst_pkg::OP_DELETE);
        ctrl.do_add = (op_q == uvst_pkg::OP_ADD) && !any_hit && (used < CAP_X);
        state_next  = uvst_pkg::S_IDLE;
      end
      default: begin
        state_next = uvst_pkg::S_IDLE;
      end
    endcase
  end

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= uvst_pkg::op_t'(op);
      value_q <= value;
      index_q <= index;
    end
  end

  // Row of cells; each takes the entry of the cell above it on delete.
  assign del_c[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [uvst_pkg::VALUE_W-1:0] up;
    if (i == CAPACITY - 1) begin : g_top
      assign up = ent[i];
    end else begin : g_mid
      assign up = ent[i+1];
    end
    uvst_cell #(
      .XW  (XW),
      .POS (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (used),
      .index    (index_q),
      .entry_up (up),
      .del_in   (del_c[i]),
      .entry    (ent[i]),
      .del_out  (del_c[i+1]),
      .hit      (hit_v[i]),
      .rd       (rdv[i])
    );
  end

  // Gather match and read data from the row.
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | rdv[k];
    end
  end
  assign any_hit  = |hit_v;
  assign in_range = XW'(index_q) < used;

  // Fill count and result fields for the update phase.
  always_comb begin
    used_next    = used;
    status_next  = uvst_pkg::ST_OK;
    element_next = '0;
    case (op_q)
      uvst_pkg::OP_ADD: begin
        if (!any_hit) begin
          if (used < CAP_X) begin
            used_next = used + XW'(1);
          end else begin
            status_next = uvst_pkg::ST_FULL;
          end
        end
      end
      uvst_pkg::OP_DELETE: begin
        if (any_hit) begin
          used_next = used - XW'(1);
        end
      end
      uvst_pkg::OP_READ: begin
        if (in_range) begin
          element_next = rd_or;
        end else begin
          status_next = uvst_pkg::ST_RANGE;
        end
      end
      default: begin
        used_next = used;
      end
    endcase
  end

  // Fill count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == uvst_pkg::S_EXEC) begin
      used <= used_next;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == uvst_pkg::S_EXEC;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == uvst_pkg::S_EXEC) begin
      found   <= any_hit;
      count   <= used_next[uvst_pkg::COUNT_W-1:0];
      status  <= status_next;
      element <= element_next;
    end
  end

`ifndef SYNTHESIS
  // A result appears only right after an update phase.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == uvst_pkg::S_EXEC)
    else $error("result strobe without an update phase");

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CAP_X)
    else $error("fill count above capacity");

  // Stored values are distinct, so at most one cell matches.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == uvst_pkg::S_EXEC |-> $onehot0(hit_v))
    else $error("more than one cell matched");

  // Every accepted request gives its result strobe.
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##2 done)
    else $error("accepted request gave no result");

  // The fill count changes only in the update phase.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state != uvst_pkg::S_EXEC |=> used == $past(used))
    else $error("fill count changed outside the update phase");
`endif

endmodule
`default_nettype wire
